[rtl/cco_pkg.sv]
`default_nettype none
package cco_pkg;

   // Parameter fractions: 32 fraction bits, one extra bit to hold exactly one
   localparam int PARAM_BITS = 32;
   localparam int QUOT_W     = PARAM_BITS + 1;

   // Threshold register width and config index width
   localparam int LIMIT_W    = 32;
   localparam int CSR_IDX_W  = 3;

   // Digit width of the partial-product multiplier
   localparam int DIGIT_W    = 32;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OWN_START_X,
      REG_OWN_START_Y,
      REG_OWN_START_Z,
      REG_OWN_END_X,
      REG_OWN_END_Y,
      REG_OWN_END_Z,
      REG_OWN_RADIUS,
      REG_NEAR_ZERO_LIMIT
   } csr_reg_type;

   // Register stages of cco_mul for a wa x wb product
   function automatic int mul_latency(input int wa, input int wb);
      return ((wa + DIGIT_W - 1) / DIGIT_W) * ((wb + DIGIT_W - 1) / DIGIT_W) + 3;
   endfunction

endpackage
`default_nettype wire

[rtl/cco_mul.sv]
`default_nettype none
// Pipelined signed multiplier: one DIGIT_W x DIGIT_W partial product per stage,
// accumulated one stage behind.
module cco_mul
   import cco_pkg::*;
#(
   parameter int WA = 68,
   parameter int WB = 68
) (
   input  logic                    clock,
   input  logic signed [WA-1:0]    op_a,
   input  logic signed [WB-1:0]    op_b,
   output logic signed [WA+WB-1:0] prod
);

   localparam int NDA   = (WA + DIGIT_W - 1) / DIGIT_W;
   localparam int NDB   = (WB + DIGIT_W - 1) / DIGIT_W;
   localparam int K     = NDA * NDB;
   localparam int AW    = NDA * DIGIT_W;
   localparam int BW    = NDB * DIGIT_W;
   localparam int ACC_W = AW + BW;

   logic [AW-1:0]          amag_ff [0:K-1];
   logic [BW-1:0]          bmag_ff [0:K-1];
   logic                   neg_ff  [0:K+1];
   logic [2*DIGIT_W-1:0]   pp_ff   [1:K];
   logic [ACC_W-1:0]       acc_ff  [1:K];
   logic [ACC_W-1:0]       sum_ff;
   logic signed [WA+WB-1:0] prod_ff;

   logic [WA-1:0] amag_in;
   logic [WB-1:0] bmag_in;

   // Sign and magnitude split
   assign amag_in = op_a[WA-1] ? (~op_a + 1'b1) : op_a;
   assign bmag_in = op_b[WB-1] ? (~op_b + 1'b1) : op_b;

   always_ff @(posedge clock) begin
      amag_ff[0] <= AW'(amag_in);
      bmag_ff[0] <= BW'(bmag_in);
      neg_ff[0]  <= op_a[WA-1] ^ op_b[WB-1];
   end

   // Partial products and running sum
   for (genvar k = 1; k <= K; k++) begin : g_pp
      localparam int IA = (k - 1) / NDB;
      localparam int IB = (k - 1) % NDB;
      always_ff @(posedge clock) begin
         pp_ff[k]  <= amag_ff[k-1][IA*DIGIT_W +: DIGIT_W]
                    * bmag_ff[k-1][IB*DIGIT_W +: DIGIT_W];
         neg_ff[k] <= neg_ff[k-1];
      end
      if (k < K) begin : g_ops
         always_ff @(posedge clock) begin
            amag_ff[k] <= amag_ff[k-1];
            bmag_ff[k] <= bmag_ff[k-1];
         end
      end
      if (k == 1) begin : g_acc_first
         always_ff @(posedge clock) begin
            acc_ff[k] <= '0;
         end
      end else begin : g_acc
         localparam int SHP = DIGIT_W * ((k - 2) / NDB + (k - 2) % NDB);
         always_ff @(posedge clock) begin
            acc_ff[k] <= acc_ff[k-1] + (ACC_W'(pp_ff[k-1]) << SHP);
         end
      end
   end

   localparam int SHL = DIGIT_W * ((K - 1) / NDB + (K - 1) % NDB);

   // Last partial product, then restore the sign
   always_ff @(posedge clock) begin
      sum_ff      <= acc_ff[K] + (ACC_W'(pp_ff[K]) << SHL);
      neg_ff[K+1] <= neg_ff[K];
      prod_ff     <= neg_ff[K+1] ? -$signed(sum_ff[WA+WB-1:0])
                                 : $signed(sum_ff[WA+WB-1:0]);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

[rtl/capsule_capsule_overlap.sv]
`default_nettype none
// Capsule overlap test, fully pipelined. A capsule held in the csr registers is
// tested against one capsule per clock: a beat is taken whenever start is high
// (busy stays low, the pipeline never blocks) and rsp_valid pulses for one cycle
// with rsp_overlap once the beat has passed the 33-step restoring divider for the
// two segment parameters and the two partial-product multiplier pipelines
// (denominator/numerators and squared distance). The receiver cannot stall
// rsp_*; take every pulse. Write csr registers only while no beat is in flight.
// Coordinates are signed fixed point; only their common scale matters, so the
// number of fraction bits does not enter the logic.
module capsule_capsule_overlap
   import cco_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_other_start_x,
   input  logic [COORD_BITS-1:0] req_other_start_y,
   input  logic [COORD_BITS-1:0] req_other_start_z,
   input  logic [COORD_BITS-1:0] req_other_end_x,
   input  logic [COORD_BITS-1:0] req_other_end_y,
   input  logic [COORD_BITS-1:0] req_other_end_z,
   input  logic [COORD_BITS-2:0] req_other_radius,
   output logic                  rsp_valid,
   output logic                  rsp_overlap,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W)-1:0] csr_wdata
);

   localparam int C       = COORD_BITS;
   localparam int DW      = C + 1;
   localparam int PW      = 2 * DW;
   localparam int P       = PW + 2;
   localparam int N       = 2 * P + 1;
   localparam int QW      = QUOT_W;
   localparam int PUW     = DW + QW + 1;
   localparam int DF      = DW + QW + 2;
   localparam int D2      = 2 * DF + 2;
   localparam int RSQ_W   = 2 * C;
   localparam int LM      = mul_latency(P, P);
   localparam int LM2     = mul_latency(DF, DF);
   localparam int GEO_LEN = 41 + LM;
   localparam int RSQ_LEN = 42 + LM + LM2;
   localparam int TOT     = 46 + LM + LM2;

   // ------------------------------------------------------------------
   // Configuration registers
   logic [2:0][C-1:0]    own_start_ff;
   logic [2:0][C-1:0]    own_end_ff;
   logic [C-2:0]         own_radius_ff;
   logic [LIMIT_W-1:0]   near_zero_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_start_ff       <= '0;
         own_end_ff         <= '0;
         own_radius_ff      <= '0;
         near_zero_limit_ff <= LIMIT_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_OWN_START_X:     own_start_ff[0]    <= csr_wdata[C-1:0];
            REG_OWN_START_Y:     own_start_ff[1]    <= csr_wdata[C-1:0];
            REG_OWN_START_Z:     own_start_ff[2]    <= csr_wdata[C-1:0];
            REG_OWN_END_X:       own_end_ff[0]      <= csr_wdata[C-1:0];
            REG_OWN_END_Y:       own_end_ff[1]      <= csr_wdata[C-1:0];
            REG_OWN_END_Z:       own_end_ff[2]      <= csr_wdata[C-1:0];
            REG_OWN_RADIUS:      own_radius_ff      <= csr_wdata[C-2:0];
            REG_NEAR_ZERO_LIMIT: near_zero_limit_ff <= csr_wdata[LIMIT_W-1:0];
         endcase
      end
   end

   logic signed [N-1:0] lim_s;
   assign lim_s = $signed({{(N-LIMIT_W){1'b0}}, near_zero_limit_ff});

   // Pipeline never blocks
   assign busy = 1'b0;

   // Valid bits
   logic vld_ff [0:TOT-1];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int i = 1; i < TOT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: segment direction vectors, start offset and radius sum
   logic [2:0][C-1:0]  req_start;
   logic [2:0][C-1:0]  req_end;
   logic [2:0][DW-1:0] u1_in, v1_in, w1_in;
   logic [2:0][DW-1:0] u1_ff, v1_ff, w1_ff;
   logic [C-1:0]       rsum1_in, rsum1_ff;

   assign req_start = {req_other_start_z, req_other_start_y, req_other_start_x};
   assign req_end   = {req_other_end_z, req_other_end_y, req_other_end_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u1_in[k] = {own_end_ff[k][C-1], own_end_ff[k]}
                  - {own_start_ff[k][C-1], own_start_ff[k]};
         v1_in[k] = {req_end[k][C-1], req_end[k]} - {req_start[k][C-1], req_start[k]};
         w1_in[k] = {own_start_ff[k][C-1], own_start_ff[k]}
                  - {req_start[k][C-1], req_start[k]};
      end
      rsum1_in = C'(own_radius_ff) + C'(req_other_radius);
   end

   always_ff @(posedge clock) begin
      u1_ff    <= u1_in;
      v1_ff    <= v1_in;
      w1_ff    <= w1_in;
      rsum1_ff <= rsum1_in;
   end

   // Stage 2: per-axis products of the five dot products (a b c d e), squared radius sum
   logic signed [PW-1:0] prod2_ff [0:4][0:2];
   logic [RSQ_W-1:0]     rsq2_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod2_ff[0][k] <= $signed(u1_ff[k]) * $signed(u1_ff[k]);
         prod2_ff[1][k] <= $signed(u1_ff[k]) * $signed(v1_ff[k]);
         prod2_ff[2][k] <= $signed(v1_ff[k]) * $signed(v1_ff[k]);
         prod2_ff[3][k] <= $signed(u1_ff[k]) * $signed(w1_ff[k]);
         prod2_ff[4][k] <= $signed(v1_ff[k]) * $signed(w1_ff[k]);
      end
      rsq2_ff <= rsum1_ff * rsum1_ff;
   end

   // Stage 3: dot product sums
   logic signed [P-1:0] dot3_ff [0:4];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) begin
         dot3_ff[i] <= P'(prod2_ff[i][0]) + P'(prod2_ff[i][1]) + P'(prod2_ff[i][2]);
      end
   end

   // Geometry and squared radius sum ride along in delay lines
   logic [8:0][DW-1:0] geo1;
   logic [8:0][DW-1:0] geo_dly_ff [0:GEO_LEN-1];
   logic [RSQ_W-1:0]   rsq_dly_ff [0:RSQ_LEN-1];

   assign geo1 = {w1_ff, v1_ff, u1_ff};

   always_ff @(posedge clock) begin
      geo_dly_ff[0] <= geo1;
      for (int i = 1; i < GEO_LEN; i++) geo_dly_ff[i] <= geo_dly_ff[i-1];
      rsq_dly_ff[0] <= rsq2_ff;
      for (int i = 1; i < RSQ_LEN; i++) rsq_dly_ff[i] <= rsq_dly_ff[i-1];
   end

   // ------------------------------------------------------------------
   // Wide products for the denominator and both numerators
   logic signed [2*P-1:0] ac_m, bb_m, be_m, cd_m, ae_m, bd_m;

   cco_mul #(.WA(P), .WB(P)) u_mul_ac (
      .clock(clock), .op_a(dot3_ff[0]), .op_b(dot3_ff[2]), .prod(ac_m));
   cco_mul #(.WA(P), .WB(P)) u_mul_bb (
      .clock(clock), .op_a(dot3_ff[1]), .op_b(dot3_ff[1]), .prod(bb_m));
   cco_mul #(.WA(P), .WB(P)) u_mul_be (
      .clock(clock), .op_a(dot3_ff[1]), .op_b(dot3_ff[4]), .prod(be_m));
   cco_mul #(.WA(P), .WB(P)) u_mul_cd (
      .clock(clock), .op_a(dot3_ff[2]), .op_b(dot3_ff[3]), .prod(cd_m));
   cco_mul #(.WA(P), .WB(P)) u_mul_ae (
      .clock(clock), .op_a(dot3_ff[0]), .op_b(dot3_ff[4]), .prod(ae_m));
   cco_mul #(.WA(P), .WB(P)) u_mul_bd (
      .clock(clock), .op_a(dot3_ff[1]), .op_b(dot3_ff[3]), .prod(bd_m));

   logic [4:0][P-1:0] dot3_pk;
   logic [4:0][P-1:0] dot_dly_ff [0:LM-1];

   assign dot3_pk = {dot3_ff[4], dot3_ff[3], dot3_ff[2], dot3_ff[1], dot3_ff[0]};

   always_ff @(posedge clock) begin
      dot_dly_ff[0] <= dot3_pk;
      for (int i = 1; i < LM; i++) dot_dly_ff[i] <= dot_dly_ff[i-1];
   end

   // Stage 4: denominator and numerators
   logic signed [N-1:0] den4_ff, sn4_ff, tn4_ff;
   logic [4:0][P-1:0]   dot4_ff;

   always_ff @(posedge clock) begin
      den4_ff <= N'(ac_m) - N'(bb_m);
      sn4_ff  <= N'(be_m) - N'(cd_m);
      tn4_ff  <= N'(ae_m) - N'(bd_m);
      dot4_ff <= dot_dly_ff[LM-1];
   end

   // Stage 5: near-parallel and s-range flags, helper sums
   logic signed [N-1:0] a4x, b4x, c4x, d4x, e4x;
   logic                par5_ff, sneg5_ff, sbig5_ff;
   logic signed [N-1:0] den5_ff, sn5_ff, tn5_ff, a5_ff, c5_ff, e5_ff;
   logic signed [N-1:0] eb5_ff, nd5_ff, bd5_ff;

   assign a4x = N'($signed(dot4_ff[0]));
   assign b4x = N'($signed(dot4_ff[1]));
   assign c4x = N'($signed(dot4_ff[2]));
   assign d4x = N'($signed(dot4_ff[3]));
   assign e4x = N'($signed(dot4_ff[4]));

   always_ff @(posedge clock) begin
      par5_ff  <= den4_ff < lim_s;
      sneg5_ff <= sn4_ff[N-1];
      sbig5_ff <= sn4_ff > den4_ff;
      den5_ff  <= den4_ff;
      sn5_ff   <= sn4_ff;
      tn5_ff   <= tn4_ff;
      a5_ff    <= a4x;
      c5_ff    <= c4x;
      e5_ff    <= e4x;
      eb5_ff   <= e4x + b4x;
      nd5_ff   <= -d4x;
      bd5_ff   <= b4x - d4x;
   end

   // Stage 6: first choice of s and t fractions
   logic signed [N-1:0] sn6_in, sd6_in, tn6_in, td6_in;
   logic signed [N-1:0] sn6_ff, sd6_ff, tn6_ff, td6_ff, a6_ff, nd6_ff, bd6_ff;
   logic                ndneg6_ff, ndbig6_ff, bdneg6_ff, bdbig6_ff;

   always_comb begin
      sn6_in = sn5_ff;
      sd6_in = den5_ff;
      tn6_in = tn5_ff;
      td6_in = den5_ff;
      if (par5_ff) begin
         sn6_in = '0;
         sd6_in = N'(1);
         tn6_in = e5_ff;
         td6_in = c5_ff;
      end else if (sneg5_ff) begin
         sn6_in = '0;
         tn6_in = e5_ff;
         td6_in = c5_ff;
      end else if (sbig5_ff) begin
         sn6_in = den5_ff;
         tn6_in = eb5_ff;
         td6_in = c5_ff;
      end
   end

   always_ff @(posedge clock) begin
      sn6_ff    <= sn6_in;
      sd6_ff    <= sd6_in;
      tn6_ff    <= tn6_in;
      td6_ff    <= td6_in;
      a6_ff     <= a5_ff;
      nd6_ff    <= nd5_ff;
      bd6_ff    <= bd5_ff;
      ndneg6_ff <= nd5_ff[N-1];
      ndbig6_ff <= nd5_ff > a5_ff;
      bdneg6_ff <= bd5_ff[N-1];
      bdbig6_ff <= bd5_ff > a5_ff;
   end

   // Stage 7: t-range flags
   logic                tneg7_ff, tbig7_ff;
   logic signed [N-1:0] sn7_ff, sd7_ff, tn7_ff, td7_ff, a7_ff, nd7_ff, bd7_ff;
   logic                ndneg7_ff, ndbig7_ff, bdneg7_ff, bdbig7_ff;

   always_ff @(posedge clock) begin
      tneg7_ff  <= tn6_ff[N-1];
      tbig7_ff  <= tn6_ff > td6_ff;
      sn7_ff    <= sn6_ff;
      sd7_ff    <= sd6_ff;
      tn7_ff    <= tn6_ff;
      td7_ff    <= td6_ff;
      a7_ff     <= a6_ff;
      nd7_ff    <= nd6_ff;
      bd7_ff    <= bd6_ff;
      ndneg7_ff <= ndneg6_ff;
      ndbig7_ff <= ndbig6_ff;
      bdneg7_ff <= bdneg6_ff;
      bdbig7_ff <= bdbig6_ff;
   end

   // Stage 8: clamp t, recompute s on the clamped edge
   logic signed [N-1:0] x8;
   logic                xneg8, xbig8;
   logic signed [N-1:0] sn8_in, sd8_in, tn8_in;
   logic signed [N-1:0] sn8_ff, sd8_ff, tn8_ff, td8_ff;

   assign x8    = tneg7_ff ? nd7_ff : bd7_ff;
   assign xneg8 = tneg7_ff ? ndneg7_ff : bdneg7_ff;
   assign xbig8 = tneg7_ff ? ndbig7_ff : bdbig7_ff;

   always_comb begin
      sn8_in = sn7_ff;
      sd8_in = sd7_ff;
      tn8_in = tn7_ff;
      if (tneg7_ff || tbig7_ff) begin
         tn8_in = tneg7_ff ? '0 : td7_ff;
         if (xneg8) begin
            sn8_in = '0;
         end else if (xbig8) begin
            sn8_in = sd7_ff;
         end else begin
            sn8_in = x8;
            sd8_in = a7_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sn8_ff <= sn8_in;
      sd8_ff <= sd8_in;
      tn8_ff <= tn8_in;
      td8_ff <= td7_ff;
   end

   // Stage 9: fractions forced to zero (small numerator, numerator above divisor or unusable divisor)
   logic                zs9_ff, zt9_ff;
   logic signed [N-1:0] sn9_ff, sd9_ff, tn9_ff, td9_ff;

   always_ff @(posedge clock) begin
      zs9_ff <= sn8_ff < 0 || sn8_ff < lim_s || sd8_ff <= 0 || sn8_ff > sd8_ff;
      zt9_ff <= tn8_ff < 0 || tn8_ff < lim_s || td8_ff <= 0 || tn8_ff > td8_ff;
      sn9_ff <= sn8_ff;
      sd9_ff <= sd8_ff;
      tn9_ff <= tn8_ff;
      td9_ff <= td8_ff;
   end

   // ------------------------------------------------------------------
   // Restoring dividers: one quotient bit per stage, MSB (the integer bit) first
   logic [N:0]    drs_ff [0:QW-1];
   logic [N:0]    drt_ff [0:QW-1];
   logic [N-1:0]  dds_ff [0:QW-1];
   logic [N-1:0]  ddt_ff [0:QW-1];
   logic [QW-1:0] dqs_ff [0:QW-1];
   logic [QW-1:0] dqt_ff [0:QW-1];
   logic          dzs_ff [0:QW-1];
   logic          dzt_ff [0:QW-1];

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [N:0]    rs_prev, rt_prev, rs_sh, rt_sh;
      logic [N-1:0]  ds_prev, dt_prev;
      logic [QW-1:0] qs_prev, qt_prev;
      logic          zs_prev, zt_prev, ges, get;

      if (j == 0) begin : g_first
         assign rs_prev = {1'b0, sn9_ff};
         assign rt_prev = {1'b0, tn9_ff};
         assign ds_prev = sd9_ff;
         assign dt_prev = td9_ff;
         assign qs_prev = '0;
         assign qt_prev = '0;
         assign zs_prev = zs9_ff;
         assign zt_prev = zt9_ff;
         assign rs_sh   = rs_prev;
         assign rt_sh   = rt_prev;
      end else begin : g_next
         assign rs_prev = drs_ff[j-1];
         assign rt_prev = drt_ff[j-1];
         assign ds_prev = dds_ff[j-1];
         assign dt_prev = ddt_ff[j-1];
         assign qs_prev = dqs_ff[j-1];
         assign qt_prev = dqt_ff[j-1];
         assign zs_prev = dzs_ff[j-1];
         assign zt_prev = dzt_ff[j-1];
         assign rs_sh   = {rs_prev[N-1:0], 1'b0};
         assign rt_sh   = {rt_prev[N-1:0], 1'b0};
      end

      assign ges = rs_sh >= {1'b0, ds_prev};
      assign get = rt_sh >= {1'b0, dt_prev};

      always_ff @(posedge clock) begin
         drs_ff[j] <= ges ? rs_sh - {1'b0, ds_prev} : rs_sh;
         drt_ff[j] <= get ? rt_sh - {1'b0, dt_prev} : rt_sh;
         dqs_ff[j] <= {qs_prev[QW-2:0], ges};
         dqt_ff[j] <= {qt_prev[QW-2:0], get};
         dds_ff[j] <= ds_prev;
         ddt_ff[j] <= dt_prev;
         dzs_ff[j] <= zs_prev;
         dzt_ff[j] <= zt_prev;
      end
   end

   // ------------------------------------------------------------------
   // Stage 43: scale directions by the fractions
   logic [QW-1:0]         sc, tc;
   logic [8:0][DW-1:0]    geo42;
   logic signed [PUW-1:0] pu43_ff [0:2];
   logic signed [PUW-1:0] pv43_ff [0:2];
   logic [2:0][DW-1:0]    w43_ff;

   assign sc    = dzs_ff[QW-1] ? '0 : dqs_ff[QW-1];
   assign tc    = dzt_ff[QW-1] ? '0 : dqt_ff[QW-1];
   assign geo42 = geo_dly_ff[GEO_LEN-1];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         pu43_ff[k] <= $signed(geo42[k]) * $signed({1'b0, sc});
         pv43_ff[k] <= $signed(geo42[3+k]) * $signed({1'b0, tc});
         w43_ff[k]  <= geo42[6+k];
      end
   end

   // Stage 44: closest-point difference at fraction scale
   logic signed [DF-1:0] df44_ff [0:2];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         df44_ff[k] <= DF'($signed({w43_ff[k], {PARAM_BITS{1'b0}}}))
                     + DF'(pu43_ff[k]) - DF'(pv43_ff[k]);
      end
   end

   // Squares of the difference
   logic signed [2*DF-1:0] dsq_m [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_sq
      cco_mul #(.WA(DF), .WB(DF)) u_mul_sq (
         .clock(clock), .op_a(df44_ff[k]), .op_b(df44_ff[k]), .prod(dsq_m[k]));
   end

   // Stage 45: squared distance
   logic [D2-1:0]    dist45_ff;
   logic [RSQ_W-1:0] rsq45_ff;

   always_ff @(posedge clock) begin
      dist45_ff <= D2'(dsq_m[0]) + D2'(dsq_m[1]) + D2'(dsq_m[2]);
      rsq45_ff  <= rsq_dly_ff[RSQ_LEN-1];
   end

   // Stage 46: compare against squared radius sum at the same scale
   logic [D2-1:0] rsq_sc;
   logic          overlap_ff;

   assign rsq_sc = D2'({rsq45_ff, {(2*PARAM_BITS){1'b0}}});

   always_ff @(posedge clock) begin
      overlap_ff <= dist45_ff <= rsq_sc;
   end

   assign rsp_valid   = vld_ff[TOT-1];
   assign rsp_overlap = overlap_ff;

endmodule
`default_nettype wire
